// ===== hw/rtl/dpc_pkg.sv =====
// ----------------------------------------------------------------------------
// dpc_pkg
// Shared types and constants for the detile and pixel convert block.
// ----------------------------------------------------------------------------
package dpc_pkg;

  // image limits and tile geometry
  localparam int unsigned MaxWidth       = 8192;
  localparam int unsigned MaxHeight      = 8192;
  localparam int unsigned TileWidth      = 64;
  localparam int unsigned TileSizeFull   = 4096;
  localparam int unsigned TileSizeHalf   = 2048;
  localparam int unsigned PitchLimit     = 32768;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_FORMAT = 3'd2,
    CFG_TILED  = 3'd3,
    CFG_PITCH  = 3'd4
  } cfg_idx_e;

  // source pixel formats, code three behaves as bgra8
  typedef enum logic [1:0] {
    FMT_BGRA8   = 2'd0,
    FMT_BGRA10  = 2'd1,
    FMT_RGBA16F = 2'd2
  } fmt_e;

  // input request
  typedef struct packed {
    logic [63:0] raw_pixel;
    logic        frame_start;
  } in_pixel_t;

  // result request
  typedef struct packed {
    logic [12:0] pos_x;
    logic [12:0] pos_y;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
  } out_pixel_t;

  // configuration seen by the position counters
  typedef struct packed {
    logic [13:0] width;
    logic [13:0] height;
    logic        half;
    logic        tiled;
    logic [15:0] pitch;
  } cfg_t;

  // placed position of the current request
  typedef struct packed {
    logic [12:0] x;
    logic [12:0] y;
    logic        visible;
  } pos_t;

endpackage

// ===== hw/rtl/dpc_half_to_byte.sv =====
// ----------------------------------------------------------------------------
// dpc_half_to_byte
// Converts one half float channel to an 8-bit value, round half up.
// ----------------------------------------------------------------------------
module dpc_half_to_byte (
  input  logic [15:0] half_i,
  output logic [7:0]  byte_o
);

  logic        sign;
  logic [4:0]  expo;
  logic [10:0] mant;
  logic [18:0] scaled;
  logic [23:0] rounded;
  logic [23:0] shifted;

  // mantissa with hidden one times 255, plus rounding bit, then scale down
  always_comb begin
    sign    = half_i[15];
    expo    = half_i[14:10];
    mant    = {1'b1, half_i[9:0]};
    scaled  = {mant, 8'd0} - 19'(mant);
    rounded = 24'(scaled) + (24'd1 << (5'd24 - expo));
    shifted = rounded >> (5'd25 - expo);
    if (sign || expo == 5'd0) begin
      byte_o = 8'd0;
    end else if (expo >= 5'd15) begin
      byte_o = 8'hff;
    end else begin
      byte_o = shifted[7:0];
    end
  end

endmodule

// ===== hw/rtl/dpc_position.sv =====
// ----------------------------------------------------------------------------
// dpc_position
// Tiled and linear position counters; places each request and flags whether
// it lands inside the visible image.
// ----------------------------------------------------------------------------
module dpc_position (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  logic          frame_start_i,
  input  dpc_pkg::cfg_t cfg_i,
  output dpc_pkg::pos_t pos_o
);

  logic [11:0] tile_idx_q, tile_idx_d, tile_idx_cur;
  logic [6:0]  tile_col_q, tile_col_d, tile_col_cur;
  logic [7:0]  tile_row_q, tile_row_d, tile_row_cur;
  logic [14:0] lin_col_q, lin_col_d, lin_col_cur;
  logic [12:0] lin_row_q, lin_row_d, lin_row_cur;

  logic [13:0] w_clamp, h_clamp;
  logic [7:0]  tiles_per_row;
  logic [14:0] w_round;
  logic [15:0] pitch;
  logic [5:0]  ex, ey;
  logic        last_in_tile;
  logic [14:0] x_full;
  logic [13:0] y_full;

  // clamp size registers, tiles per row, effective pitch
  always_comb begin
    w_clamp = (cfg_i.width > 14'(dpc_pkg::MaxWidth)) ? 14'(dpc_pkg::MaxWidth) : cfg_i.width;
    h_clamp = (cfg_i.height > 14'(dpc_pkg::MaxHeight)) ? 14'(dpc_pkg::MaxHeight)
                                                        : cfg_i.height;
    w_round = 15'(w_clamp) + 15'(dpc_pkg::TileWidth - 1);
    tiles_per_row = w_round[13:6];
    if (tiles_per_row == 8'd0) begin
      tiles_per_row = 8'd1;
    end
    pitch = cfg_i.pitch;
    if (pitch == 16'd0) begin
      pitch = 16'd1;
    end else if (pitch > 16'(dpc_pkg::PitchLimit)) begin
      pitch = 16'(dpc_pkg::PitchLimit);
    end
  end

  // counters as seen by this request, cleared on frame start
  always_comb begin
    tile_idx_cur = frame_start_i ? '0 : tile_idx_q;
    tile_col_cur = frame_start_i ? '0 : tile_col_q;
    tile_row_cur = frame_start_i ? '0 : tile_row_q;
    lin_col_cur  = frame_start_i ? '0 : lin_col_q;
    lin_row_cur  = frame_start_i ? '0 : lin_row_q;
  end

  // z-order deinterleave, row masked to the tile height
  always_comb begin
    for (int i = 0; i < 6; i++) begin
      ex[i] = tile_idx_cur[2*i];
      ey[i] = tile_idx_cur[2*i+1];
    end
    if (cfg_i.half) begin
      ey[5] = 1'b0;
    end
  end

  // position select and next counter values
  always_comb begin
    tile_idx_d = tile_idx_cur;
    tile_col_d = tile_col_cur;
    tile_row_d = tile_row_cur;
    lin_col_d  = lin_col_cur;
    lin_row_d  = lin_row_cur;
    last_in_tile = cfg_i.half
      ? (13'(tile_idx_cur) + 13'd1 >= 13'(dpc_pkg::TileSizeHalf))
      : (13'(tile_idx_cur) + 13'd1 >= 13'(dpc_pkg::TileSizeFull));
    if (cfg_i.tiled) begin
      x_full = 15'({tile_col_cur, ex});
      y_full = cfg_i.half ? {1'b0, tile_row_cur, ey[4:0]} : {tile_row_cur, ey};
      if (last_in_tile) begin
        tile_idx_d = '0;
        if (8'(tile_col_cur) + 8'd1 >= tiles_per_row) begin
          tile_col_d = '0;
          tile_row_d = tile_row_cur + 8'd1;
        end else begin
          tile_col_d = tile_col_cur + 7'd1;
        end
      end else begin
        tile_idx_d = tile_idx_cur + 12'd1;
      end
    end else begin
      x_full = lin_col_cur;
      y_full = 14'(lin_row_cur);
      if (16'(lin_col_cur) + 16'd1 >= pitch) begin
        lin_col_d = '0;
        lin_row_d = lin_row_cur + 13'd1;
      end else begin
        lin_col_d = lin_col_cur + 15'd1;
      end
    end
    pos_o.x       = x_full[12:0];
    pos_o.y       = y_full[12:0];
    pos_o.visible = (x_full < 15'(w_clamp)) && (y_full < h_clamp);
  end

  // counter registers, advance on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_idx_q <= '0;
      tile_col_q <= '0;
      tile_row_q <= '0;
      lin_col_q  <= '0;
      lin_row_q  <= '0;
    end else if (accept_i) begin
      tile_idx_q <= tile_idx_d;
      tile_col_q <= tile_col_d;
      tile_row_q <= tile_row_d;
      lin_col_q  <= lin_col_d;
      lin_row_q  <= lin_row_d;
    end
  end

endmodule

// ===== hw/rtl/detile_pixel_convert.sv =====
// ----------------------------------------------------------------------------
// detile_pixel_convert
// Places streamed source pixels in the linear image and converts them to
// 8-bit rgb; pixels outside the visible image are dropped.
// ----------------------------------------------------------------------------
// throughput: one request per cycle while the output is not stalled, through
//   a placement register and then a result register; the position counters
//   update in the accepting cycle
// reset: position counters and pipeline valids clear, config registers take
//   width 64, height 64, bgra8, tiled, pitch 64
module detile_pixel_convert (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dpc_pkg::in_pixel_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dpc_pkg::out_pixel_t out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i
);

  logic [13:0]  width_q, height_q;
  dpc_pkg::fmt_e format_q;
  logic          tiled_q;
  logic [15:0]   pitch_q;

  dpc_pkg::cfg_t cfg;
  dpc_pkg::pos_t pos;

  logic          in_acc, out_free, s1_free;
  logic          s1_valid_q;
  logic [12:0]   s1_x_q, s1_y_q;
  logic [63:0]   s1_raw_q;
  dpc_pkg::fmt_e s1_fmt_q;

  logic [7:0]    half_r, half_g, half_b;
  dpc_pkg::out_pixel_t conv;

  logic                out_valid_q;
  dpc_pkg::out_pixel_t out_q;

  // configuration writes
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 14'd64;
      height_q <= 14'd64;
      format_q <= dpc_pkg::FMT_BGRA8;
      tiled_q  <= 1'b1;
      pitch_q  <= 16'd64;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (dpc_pkg::cfg_idx_e'(cfg_index_i))
        dpc_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[13:0];
        dpc_pkg::CFG_HEIGHT: height_q <= cfg_data_i[13:0];
        dpc_pkg::CFG_FORMAT: format_q <= dpc_pkg::fmt_e'(cfg_data_i[1:0]);
        dpc_pkg::CFG_TILED:  tiled_q  <= cfg_data_i[0];
        dpc_pkg::CFG_PITCH:  pitch_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cfg.width  = width_q;
    cfg.height = height_q;
    cfg.half   = (format_q == dpc_pkg::FMT_RGBA16F);
    cfg.tiled  = tiled_q;
    cfg.pitch  = pitch_q;
  end

  // pipeline flow control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign s1_free    = !s1_valid_q || out_free;
  assign in_stall_o = !s1_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // position counters
  dpc_position u_position (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .frame_start_i (in_data_i.frame_start),
    .cfg_i         (cfg),
    .pos_o         (pos)
  );

  // placement register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_acc && pos.visible;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_x_q   <= pos.x;
      s1_y_q   <= pos.y;
      s1_raw_q <= in_data_i.raw_pixel;
      s1_fmt_q <= format_q;
    end
  end

  // half float channels
  dpc_half_to_byte u_half_r (.half_i(s1_raw_q[15:0]),  .byte_o(half_r));
  dpc_half_to_byte u_half_g (.half_i(s1_raw_q[31:16]), .byte_o(half_g));
  dpc_half_to_byte u_half_b (.half_i(s1_raw_q[47:32]), .byte_o(half_b));

  // color conversion
  always_comb begin
    conv.pos_x = s1_x_q;
    conv.pos_y = s1_y_q;
    case (s1_fmt_q)
      dpc_pkg::FMT_RGBA16F: begin
        conv.red   = half_r;
        conv.green = half_g;
        conv.blue  = half_b;
      end
      dpc_pkg::FMT_BGRA10: begin
        conv.blue  = s1_raw_q[9:2];
        conv.green = s1_raw_q[19:12];
        conv.red   = s1_raw_q[29:22];
      end
      default: begin
        conv.blue  = s1_raw_q[7:0];
        conv.green = s1_raw_q[15:8];
        conv.red   = s1_raw_q[23:16];
      end
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && s1_valid_q) begin
      out_q <= conv;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  // input stalls only when both stages hold requests
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // a placed request moves to the output when the output is free
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_free) |=> out_valid_o)
    else $error("placed request lost");

  // a pixel outside the image never enters the pipeline
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !pos.visible) |=> !s1_valid_q)
    else $error("invisible pixel entered pipeline");
`endif

endmodule
